>>> rtl/pbo_pkg.sv
// Shared constants, types and codes of the PolyBLEP oscillator sample core.
`default_nettype none
package pbo_pkg;

   localparam int PHASE_BITS    = 24;
   localparam int OUT_FRAC_BITS = 20;
   localparam int SAMPLE_BITS   = 24;
   localparam int Q_BITS        = OUT_FRAC_BITS + 1;
   localparam int DIV_STEPS     = Q_BITS;
   localparam int RES_BITS      = OUT_FRAC_BITS + 3;
   localparam int TWICE_SHIFT   = PHASE_BITS - OUT_FRAC_BITS - 1;
   localparam int SIN_Q         = 30;
   localparam int SIN_TERMS     = 8;
   localparam int TH_BITS       = 31;
   localparam int TH2_BITS      = 32;
   localparam int CSR_IDX_BITS  = 2;
   localparam int NUM_STAGES    = 25;

   localparam logic [32:0]           TWO_PI_Q30 = 33'd6746518852;
   localparam logic [TH_BITS-1:0]    SIN_ONE    = TH_BITS'(1) << SIN_Q;
   localparam logic [PHASE_BITS-1:0] PW_RESET   = PHASE_BITS'(1) << (PHASE_BITS - 1);

   typedef enum logic [2:0] {
      WAVE_SAW      = 3'd0,
      WAVE_SQUARE   = 3'd1,
      WAVE_TRIANGLE = 3'd2,
      WAVE_SINE     = 3'd3,
      WAVE_PULSE    = 3'd4
   } wave_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_WAVEFORM    = 2'd0,
      CSR_PULSE_WIDTH = 2'd1
   } csr_idx_type;

   typedef struct packed {
      logic [PHASE_BITS-1:0] rem;
      logic [Q_BITS-1:0]     bits;
   } div_lane_type;

   typedef struct packed {
      logic [TH_BITS-1:0]  th;
      logic [TH2_BITS-1:0] th2;
      logic [TH_BITS-1:0]  term;
      logic                neg;
   } sin_type;

   typedef struct packed {
      logic signed [RES_BITS-1:0] base;
      logic [PHASE_BITS-1:0]      dt;
      logic                       act_a;
      logic                       neg_a;
      logic                       act_b;
      logic                       neg_b;
   } side_type;

endpackage
`default_nettype wire

>>> rtl/pbo_if.sv
// Channel interfaces: request, response and register write words.
`default_nettype none
interface pbo_req_if
   import pbo_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [PHASE_BITS-1:0] phase;
   logic [PHASE_BITS-1:0] phase_step;
   modport source (output valid, output phase, output phase_step, input ready);
   modport sink (input valid, input phase, input phase_step, output ready);
endinterface

interface pbo_rsp_if
   import pbo_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface pbo_csr_if
   import pbo_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [PHASE_BITS-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/pbo_div_cell.sv
// One restoring division step for both residual lanes.
`default_nettype none
module pbo_div_cell
   import pbo_pkg::*;
(
   input  logic                  clock,
   input  logic                  en,
   input  logic [PHASE_BITS-1:0] dvs,
   input  div_lane_type [1:0]    prev_lane,
   output div_lane_type [1:0]    lane_ff
);

   div_lane_type [1:0]          lane_in;
   logic [1:0][PHASE_BITS:0]    trial;
   logic [1:0][PHASE_BITS:0]    diff;
   logic [1:0]                  ge;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         trial[l] = {prev_lane[l].rem, prev_lane[l].bits[Q_BITS-1]};
         diff[l]  = trial[l] - {1'b0, dvs};
         ge[l]    = trial[l] >= {1'b0, dvs};
         lane_in[l].rem  = ge[l] ? diff[l][PHASE_BITS-1:0] : trial[l][PHASE_BITS-1:0];
         lane_in[l].bits = {prev_lane[l].bits[Q_BITS-2:0], ge[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/pbo_sine_cell.sv
// One Horner step of the sine series: multiply, then exact divide by a constant.
`default_nettype none
module pbo_sine_cell
   import pbo_pkg::*;
#(
   parameter int K = 1
)
(
   input  logic    clock,
   input  logic    en,
   input  sin_type prev,
   output sin_type out_ff
);

   localparam int D = 2 * K * (2 * K + 1);
   localparam int L = $clog2(D);
   localparam int S = 32 + L;
   localparam logic [63:0] M = ((64'd1 << S) + 64'(D) - 64'd1) / 64'(D);

   logic [TH2_BITS+TH_BITS-1:0] prod1;
   logic [TH2_BITS-1:0]         w_in;
   logic [TH2_BITS-1:0]         w_ff;
   sin_type                     mid_ff;
   logic [S+31:0]               prod2;
   logic [31:0]                 quo;
   sin_type                     out_in;

   always_comb begin
      prod1 = prev.th2 * prev.term;
      w_in  = prod1[SIN_Q +: TH2_BITS];
      prod2 = w_ff * M[33:0];
      quo   = prod2[S +: 32];
      out_in      = mid_ff;
      out_in.term = SIN_ONE - quo[TH_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w_ff   <= w_in;
         mid_ff <= prev;
         out_ff <= out_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/pbo_out_buf.sv
// Two-word output buffer between the pipeline and the response channel.
`default_nettype none
module pbo_out_buf
   import pbo_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [SAMPLE_BITS-1:0] push_data,
   input  logic                   pop,
   output logic                   full,
   output logic                   valid,
   output logic [SAMPLE_BITS-1:0] data
);

   logic [1:0][SAMPLE_BITS-1:0] mem_ff;
   logic                        wr_ptr_ff;
   logic                        rd_ptr_ff;
   logic [1:0]                  cnt_ff;
   logic [1:0]                  cnt_in;

   assign full  = cnt_ff == 2'd2;
   assign valid = cnt_ff != 2'd0;
   assign data  = mem_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

>>> rtl/polyblep_oscillator_sample_core.sv
// Top level of the PolyBLEP oscillator sample core.
//
//   channel   role    word
//   req_chan  sink    phase, phase_step (Q0.24)
//   rsp_chan  source  sample (signed Q3.20)
//   csr_chan  sink    index, data (0 waveform, 1 pulse_width)
//
// One word accepted per cycle while the pipeline is not halted. The pipeline has 25 stages,
// set by the 21-cell divider chain and the 8 two-stage sine cells, and feeds the output
// buffer. Reset clears the pipeline valids, the output buffer and the registers. The
// pipeline halts only while the two-word output buffer is full and not being drained.
`default_nettype none
module polyblep_oscillator_sample_core
   import pbo_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   pbo_req_if.sink   req_chan,
   pbo_rsp_if.source rsp_chan,
   pbo_csr_if.sink   csr_chan
);

   localparam int P = PHASE_BITS;
   localparam int F = OUT_FRAC_BITS;
   localparam int V_BITS = SAMPLE_BITS + 2;
   localparam logic [P-1:0] HALF    = P'(1) << (P - 1);
   localparam logic [P-2:0] QUARTER = (P-1)'(1) << (P - 2);
   localparam logic [P:0]   ONE_EXT = (P+1)'(1) << P;
   localparam logic [P:0]   TW_RND  = (P+1)'(1) << (TWICE_SHIFT - 1);
   localparam logic signed [RES_BITS-1:0] ONE_OUT = RES_BITS'(1) << F;
   localparam logic signed [V_BITS-1:0] SAT_HI = V_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [V_BITS-1:0] SAT_LO = -V_BITS'(1 << (SAMPLE_BITS - 1));

   // registers
   wave_type     wave_ff;
   logic [P-1:0] pw_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff <= WAVE_SAW;
         pw_ff   <= PW_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_WAVEFORM:    wave_ff <= wave_type'(csr_chan.data[2:0]);
            CSR_PULSE_WIDTH: pw_ff   <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // flow control
   logic               en;
   logic               accept;
   logic               buf_full;
   logic               buf_valid;
   logic [SAMPLE_BITS-1:0] buf_data;
   logic [NUM_STAGES:1] vld_ff;
   logic [SAMPLE_BITS-1:0] out_ff;
   logic [SAMPLE_BITS-1:0] out_in;

   assign en             = !buf_full || rsp_chan.ready;
   assign req_chan.ready = en;
   assign accept         = req_chan.valid && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NUM_STAGES-1:1], accept};
      end
   end

   pbo_out_buf u_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (en && vld_ff[NUM_STAGES]),
      .push_data (out_ff),
      .pop       (buf_valid && rsp_chan.ready),
      .full      (buf_full),
      .valid     (buf_valid),
      .data      (buf_data)
   );

   assign rsp_chan.valid  = buf_valid;
   assign rsp_chan.sample = buf_data;

   // stage 1: edge distances, naive waveform value, sine fold
   logic [P-1:0]          p;
   logic [P-1:0]          dt;
   logic [1:0][P-1:0]     tt;
   logic [1:0]            after;
   logic [1:0]            pre_edge;
   logic [1:0][P:0]       tsum;
   logic [1:0][P-1:0]     edist;
   logic [1:0][P+F-1:0]   num;
   div_lane_type [1:0]    lane1_in;
   logic [P:0]            two_p;
   logic [P:0]            tri_a;
   logic [P:0]            tf_x;
   logic [P:0]            twice;
   logic signed [RES_BITS-1:0] base;
   side_type              side1_in;
   logic [1:0]            quad;
   logic [P-2:0]          rq;
   logic [P-2:0]          sx_in;

   always_comb begin
      p  = req_chan.phase;
      dt = req_chan.phase_step;
      tt[0] = p;
      tt[1] = (wave_ff == WAVE_PULSE) ? p - pw_ff : p + HALF;
      for (int l = 0; l < 2; l++) begin
         after[l]    = tt[l] < dt;
         tsum[l]     = {1'b0, tt[l]} + {1'b0, dt};
         pre_edge[l] = (dt != '0) && (tsum[l] > ONE_EXT);
         if (after[l]) begin
            edist[l] = dt - tt[l];
         end else if (pre_edge[l]) begin
            edist[l] = tsum[l][P-1:0];
         end else begin
            edist[l] = '0;
         end
         num[l] = {edist[l], {F{1'b0}}} + {{(F+1){1'b0}}, dt[P-1:1]};
         lane1_in[l].rem  = {1'b0, num[l][P+F-1:Q_BITS]};
         lane1_in[l].bits = num[l][Q_BITS-1:0];
      end

      two_p = {p, 1'b0};
      tri_a = (two_p >= ONE_EXT) ? two_p - ONE_EXT : ONE_EXT - two_p;
      tf_x  = (wave_ff == WAVE_TRIANGLE) ? tri_a : {1'b0, p};
      twice = (tf_x + TW_RND) >> TWICE_SHIFT;
      case (wave_ff)
         WAVE_SAW, WAVE_TRIANGLE: base = $signed(twice[RES_BITS-1:0]) - ONE_OUT;
         WAVE_SQUARE:             base = (p < HALF) ? ONE_OUT : -ONE_OUT;
         WAVE_PULSE:              base = (p < pw_ff) ? ONE_OUT : -ONE_OUT;
         default:                 base = '0;
      endcase

      side1_in.base  = base;
      side1_in.dt    = dt;
      side1_in.act_a = after[0] || pre_edge[0];
      side1_in.neg_a = after[0];
      side1_in.act_b = after[1] || pre_edge[1];
      side1_in.neg_b = after[1];

      quad  = p[P-1:P-2];
      rq    = {1'b0, p[P-3:0]};
      sx_in = quad[0] ? QUARTER - rq : rq;
   end

   // residual path: divider chain
   div_lane_type [1:0] div_ch [DIV_STEPS+1];
   side_type           side_ff [DIV_STEPS+1];
   logic [P-2:0]       sx1_ff;
   logic               sneg1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         div_ch[0]  <= lane1_in;
         side_ff[0] <= side1_in;
         sx1_ff     <= sx_in;
         sneg1_ff   <= quad[1];
         for (int s = 1; s <= DIV_STEPS; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      pbo_div_cell u_cell (
         .clock     (clock),
         .en        (en),
         .dvs       (side_ff[j].dt),
         .prev_lane (div_ch[j]),
         .lane_ff   (div_ch[j+1])
      );
   end

   // stage 23: squared residuals
   logic [1:0][2*Q_BITS-1:0]      sqp;
   logic [1:0][Q_BITS-1:0]        sq;
   logic [1:0]                    act;
   logic [1:0]                    neg;
   logic [1:0][RES_BITS-1:0]      res_in;
   logic signed [RES_BITS-1:0]    ra_ff;
   logic signed [RES_BITS-1:0]    rb_ff;
   logic signed [RES_BITS-1:0]    base23_ff;
   logic [P-1:0]                  dt23_ff;

   always_comb begin
      act[0] = side_ff[DIV_STEPS].act_a;
      neg[0] = side_ff[DIV_STEPS].neg_a;
      act[1] = side_ff[DIV_STEPS].act_b;
      neg[1] = side_ff[DIV_STEPS].neg_b;
      for (int l = 0; l < 2; l++) begin
         sqp[l] = div_ch[DIV_STEPS][l].bits * div_ch[DIV_STEPS][l].bits
                  + ((2*Q_BITS)'(1) << (F - 1));
         sq[l]  = sqp[l][F +: Q_BITS];
         if (!act[l]) begin
            res_in[l] = '0;
         end else if (neg[l]) begin
            res_in[l] = -{2'b00, sq[l]};
         end else begin
            res_in[l] = {2'b00, sq[l]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ra_ff     <= $signed(res_in[0]);
         rb_ff     <= $signed(res_in[1]);
         base23_ff <= side_ff[DIV_STEPS].base;
         dt23_ff   <= side_ff[DIV_STEPS].dt;
      end
   end

   // stage 24: combine, triangle slope product
   logic signed [RES_BITS-1:0]   ssum;
   logic [RES_BITS-2:0]          smag;
   logic [RES_BITS-2+P:0]        cprod_ff;
   logic                         cneg_ff;
   logic signed [RES_BITS+1:0]   v24_in;
   logic signed [RES_BITS+1:0]   v24_ff;

   always_comb begin
      ssum = ra_ff + rb_ff;
      smag = ssum[RES_BITS-1] ? (RES_BITS-1)'(-ssum) : ssum[RES_BITS-2:0];
      case (wave_ff)
         WAVE_SAW:                v24_in = base23_ff - ra_ff;
         WAVE_SQUARE, WAVE_PULSE: v24_in = base23_ff + ra_ff - rb_ff;
         WAVE_TRIANGLE:           v24_in = base23_ff;
         default:                 v24_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cprod_ff <= smag * dt23_ff;
         cneg_ff  <= ssum[RES_BITS-1];
         v24_ff   <= v24_in;
      end
   end

   // sine path
   logic [P+32-1:0]       thp;
   logic [TH_BITS-1:0]    th2s_ff;
   logic                  neg2_ff;
   logic [2*TH_BITS-1:0]  th2p;
   sin_type               sin3_ff;
   sin_type               sin3_in;
   sin_type               sin_ch [SIN_TERMS+1];
   logic [2*TH_BITS-1:0]  finp;
   logic [TH_BITS-1:0]    fin_ff;
   logic                  fneg_ff;
   logic [TH_BITS:0]      fin_r;
   logic [RES_BITS-1:0]   smag_s;
   logic [3:0][RES_BITS-1:0] sv_ff;
   logic [RES_BITS-1:0]   sv_in;

   always_comb begin
      thp          = sx1_ff * TWO_PI_Q30 + ((P+32)'(1) << (P - 1));
      th2p         = th2s_ff * th2s_ff;
      sin3_in.th   = th2s_ff;
      sin3_in.th2  = th2p[SIN_Q +: TH2_BITS];
      sin3_in.term = SIN_ONE;
      sin3_in.neg  = neg2_ff;
      finp         = sin_ch[SIN_TERMS].th * sin_ch[SIN_TERMS].term;
      fin_r        = {1'b0, fin_ff} + ((TH_BITS+1)'(1) << (SIN_Q - F - 1));
      smag_s       = {1'b0, fin_r[SIN_Q-F +: RES_BITS-1]};
      sv_in        = fneg_ff ? -smag_s : smag_s;
   end

   assign sin_ch[0] = sin3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         th2s_ff <= thp[P +: TH_BITS];
         neg2_ff <= sneg1_ff;
         sin3_ff <= sin3_in;
         fin_ff  <= finp[SIN_Q +: TH_BITS];
         fneg_ff <= sin_ch[SIN_TERMS].neg;
         sv_ff   <= {sv_ff[2:0], sv_in};
      end
   end

   for (genvar i = 0; i < SIN_TERMS; i++) begin : g_sin
      pbo_sine_cell #(
         .K (SIN_TERMS - i)
      ) u_cell (
         .clock  (clock),
         .en     (en),
         .prev   (sin_ch[i]),
         .out_ff (sin_ch[i+1])
      );
   end

   // stage 25: slope term, selection, saturation
   logic [RES_BITS-1+P:0]      cr;
   logic [RES_BITS:0]          cmag;
   logic signed [V_BITS-1:0]   cterm;
   logic signed [V_BITS-1:0]   vfin;

   always_comb begin
      cr    = {1'b0, cprod_ff} + ((RES_BITS+P)'(1) << (P - 2));
      cmag  = cr[P-1 +: RES_BITS+1];
      cterm = cneg_ff ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
      case (wave_ff)
         WAVE_TRIANGLE: vfin = v24_ff + cterm;
         WAVE_SINE:     vfin = $signed(sv_ff[3]);
         default:       vfin = v24_ff;
      endcase
      if (vfin > SAT_HI) begin
         out_in = SAT_HI[SAMPLE_BITS-1:0];
      end else if (vfin < SAT_LO) begin
         out_in = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         out_in = vfin[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

endmodule
`default_nettype wire

>>> bench/polyblep_oscillator_sample_core_tb.sv
// Self-checking bench for the PolyBLEP oscillator core: directed, random and back-pressure runs.
`default_nettype none
module polyblep_oscillator_sample_core_tb
   import pbo_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned PH_ONE   = 64'd1 << PHASE_BITS;
   localparam longint unsigned PH_MASK  = PH_ONE - 1;
   localparam longint          OUT_ONE  = 64'sd1 << OUT_FRAC_BITS;
   localparam longint unsigned TWO_PI   = 64'd6746518852;
   localparam int              WATCHDOG = 3000;
   localparam int              DRAIN    = 40;

   logic clock;
   logic reset;

   pbo_req_if req ();
   pbo_rsp_if rsp ();
   pbo_csr_if csr ();

   polyblep_oscillator_sample_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp),
      .csr_chan (csr)
   );

   wave_type              cur_wave;
   logic [PHASE_BITS-1:0] cur_width;

   logic signed [SAMPLE_BITS-1:0] expected_samples[$];

   int  words_sent;
   int  samples_checked;
   int  mismatches;
   int  csr_writes;
   int  quiet_cycles;
   int  burst_left;
   bit  gaps_on;
   int  rx_mode;
   bit  hold_req;
   int  hold_left;
   int  rx_tick;
   int  wave_hits[5];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- prediction ----------------

   function automatic longint blep_residual(longint unsigned t, longint unsigned dt);
      longint unsigned q;
      if (t < dt) begin
         q = (((dt - t) << OUT_FRAC_BITS) + dt / 2) / dt;
         return -longint'((q * q + (64'd1 << (OUT_FRAC_BITS - 1))) >> OUT_FRAC_BITS);
      end
      if (dt != 0 && t + dt > PH_ONE) begin
         q = (((t + dt - PH_ONE) << OUT_FRAC_BITS) + dt / 2) / dt;
         return longint'((q * q + (64'd1 << (OUT_FRAC_BITS - 1))) >> OUT_FRAC_BITS);
      end
      return 0;
   endfunction

   function automatic longint twice_ramp(longint unsigned x);
      return longint'(((x << (OUT_FRAC_BITS + 1)) + (64'd1 << (PHASE_BITS - 1))) >> PHASE_BITS);
   endfunction

   function automatic longint sine_of(longint unsigned p);
      longint unsigned quarter;
      longint unsigned quad;
      longint unsigned r;
      longint unsigned x;
      longint unsigned th;
      longint unsigned th2;
      longint unsigned term;
      longint unsigned d;
      longint unsigned s;
      longint          v;
      quarter = PH_ONE >> 2;
      quad    = (p >> (PHASE_BITS - 2)) & 3;
      r       = p & (quarter - 1);
      x       = quad[0] ? (quarter - r) : r;
      th      = (x * TWO_PI + (64'd1 << (PHASE_BITS - 1))) >> PHASE_BITS;
      th2     = (th * th) >> 30;
      term    = 64'd1 << 30;
      for (int k = 8; k >= 1; k--) begin
         d    = longint'(2 * k) * longint'(2 * k + 1);
         term = (64'd1 << 30) - ((th2 * term) >> 30) / d;
      end
      s = (th * term) >> 30;
      v = longint'((s + (64'd1 << (30 - OUT_FRAC_BITS - 1))) >> (30 - OUT_FRAC_BITS));
      return quad[1] ? -v : v;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] predict_sample(
         logic [PHASE_BITS-1:0] phase, logic [PHASE_BITS-1:0] step);
      longint unsigned p;
      longint unsigned dt;
      longint unsigned pw;
      longint unsigned a;
      longint unsigned m;
      longint          v;
      longint          s;
      longint          c;
      p  = phase;
      dt = step;
      pw = cur_width;
      v  = 0;
      case (cur_wave)
         WAVE_SAW: v = twice_ramp(p) - OUT_ONE - blep_residual(p, dt);
         WAVE_SQUARE: begin
            v = (p < (PH_ONE >> 1)) ? OUT_ONE : -OUT_ONE;
            v += blep_residual(p, dt) - blep_residual((p + (PH_ONE >> 1)) & PH_MASK, dt);
         end
         WAVE_TRIANGLE: begin
            a = (2 * p >= PH_ONE) ? (2 * p - PH_ONE) : (PH_ONE - 2 * p);
            s = blep_residual(p, dt) + blep_residual((p + (PH_ONE >> 1)) & PH_MASK, dt);
            m = (s < 0) ? longint'(-s) : longint'(s);
            c = longint'((m * dt + (64'd1 << (PHASE_BITS - 2))) >> (PHASE_BITS - 1));
            v = twice_ramp(a) - OUT_ONE + ((s < 0) ? -c : c);
         end
         WAVE_SINE: v = sine_of(p);
         WAVE_PULSE: begin
            v = (p < pw) ? OUT_ONE : -OUT_ONE;
            v += blep_residual(p, dt) - blep_residual((p + PH_ONE - pw) & PH_MASK, dt);
         end
         default: v = 0;
      endcase
      if (v < -(64'sd1 << (SAMPLE_BITS - 1))) v = -(64'sd1 << (SAMPLE_BITS - 1));
      if (v > (64'sd1 << (SAMPLE_BITS - 1)) - 1) v = (64'sd1 << (SAMPLE_BITS - 1)) - 1;
      return v[SAMPLE_BITS-1:0];
   endfunction

   // ---------------- channel drivers ----------------

   task automatic send_word(logic [PHASE_BITS-1:0] phase, logic [PHASE_BITS-1:0] step);
      if (gaps_on && burst_left <= 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 20);
      end
      req.valid      <= 1'b1;
      req.phase      <= phase;
      req.phase_step <= step;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      expected_samples.push_back(predict_sample(phase, step));
      wave_hits[cur_wave]++;
      words_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic lower_request();
      req.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      lower_request();
      while (expected_samples.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [PHASE_BITS-1:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= value;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      if (idx == CSR_WAVEFORM) cur_wave = wave_type'(value[2:0]);
      else cur_width = value;
      csr_writes++;
      @(negedge clock);
   endtask

   task automatic set_mode(wave_type w, logic [PHASE_BITS-1:0] width);
      wait_drained();
      write_reg(CSR_WAVEFORM, PHASE_BITS'(w));
      write_reg(CSR_PULSE_WIDTH, width);
      csr.valid <= 1'b0;
   endtask

   // phase biased towards the edges that the correction acts on
   function automatic logic [PHASE_BITS-1:0] pick_phase(logic [PHASE_BITS-1:0] step);
      logic [PHASE_BITS-1:0] edge_at;
      logic [PHASE_BITS-1:0] off;
      case ($urandom_range(0, 3))
         0: edge_at = '0;
         1: edge_at = PHASE_BITS'(PH_ONE >> 1);
         2: edge_at = cur_width;
         default: return PHASE_BITS'($urandom);
      endcase
      off = PHASE_BITS'($urandom_range(0, step + 1));
      return $urandom_range(0, 1) ? edge_at + off : edge_at - off;
   endfunction

   function automatic logic [PHASE_BITS-1:0] pick_step();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return PHASE_BITS'(PH_ONE >> 1);
         2, 3: return PHASE_BITS'($urandom_range(0, 32'h800000));
         default: return PHASE_BITS'($urandom_range(1, 4096));
      endcase
   endfunction

   // ---------------- receiver, checker, watchdog ----------------

   always @(negedge clock) begin
      rx_tick++;
      if (hold_req) begin
         hold_left = 400;
         hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp.ready <= 1'b0;
      end else begin
         case (rx_mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= ($urandom_range(0, 99) < 70);
            default: rsp.ready <= ($urandom_range(0, 7) != 0) && (rx_tick % 5 != 2);
         endcase
      end
   end

   always @(posedge clock) begin
      logic signed [SAMPLE_BITS-1:0] want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected sample %0d", $signed(rsp.sample));
         end else begin
            want = expected_samples.pop_front();
            samples_checked++;
            if (rsp.sample !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("sample mismatch: expected %0d got %0d", want, $signed(rsp.sample));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG) begin
         $display("watchdog: nothing accepted for %0d cycles", quiet_cycles);
         $display("Regression FAIL");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // ---------------- tests ----------------

   task automatic test_directed();
      logic [PHASE_BITS-1:0] ph[6];
      logic [PHASE_BITS-1:0] st[4];
      ph = '{24'h000000, 24'hFFFFFF, 24'h7FFFFF, 24'h800000, 24'h000100, 24'h3FFFFF};
      st = '{24'h000000, 24'h800000, 24'h000200, 24'h000001};
      for (int w = 0; w <= 4; w++) begin
         set_mode(wave_type'(w), (w == 4) ? 24'h400000 : PW_RESET);
         for (int i = 0; i < 5; i++) send_word(ph[i], st[i % 4]);
      end
      // pulse width at both extremes
      set_mode(WAVE_PULSE, 24'h000000);
      send_word(24'h000000, 24'h000100);
      send_word(24'hFFFFF0, 24'h000100);
      set_mode(WAVE_PULSE, 24'hFFFFFF);
      send_word(24'hFFFFFF, 24'h000010);
      send_word(24'h000005, 24'h800000);
   endtask

   task automatic test_random(int count);
      logic [PHASE_BITS-1:0] step;
      int done;
      done = 0;
      while (done < count) begin
         case ($urandom_range(0, 5))
            0: set_mode(wave_type'($urandom_range(0, 4)), '0);
            1: set_mode(wave_type'($urandom_range(0, 4)), 24'hFFFFFF);
            default: set_mode(wave_type'($urandom_range(0, 4)), PHASE_BITS'($urandom));
         endcase
         rx_mode = $urandom_range(0, 2);
         gaps_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(40, 110)) begin
            step = pick_step();
            send_word(pick_phase(step), step);
            done++;
         end
      end
   endtask

   task automatic test_backpressure();
      logic [PHASE_BITS-1:0] step;
      set_mode(WAVE_SQUARE, PW_RESET);
      gaps_on  = 1'b0;
      rx_mode  = 0;
      hold_req = 1'b1;
      repeat (60) begin
         step = pick_step();
         send_word(pick_phase(step), step);
      end
      wait_drained();
      // pause until drained mid-stream, then resume
      rx_mode = 1;
      repeat (20) send_word(PHASE_BITS'($urandom), pick_step());
      wait_drained();
      repeat (20) send_word(PHASE_BITS'($urandom), pick_step());
   endtask

   initial begin
      reset       = 1'b1;
      req.valid   = 1'b0;
      req.phase   = '0;
      req.phase_step = '0;
      rsp.ready   = 1'b0;
      csr.valid   = 1'b0;
      csr.index   = CSR_WAVEFORM;
      csr.data    = '0;
      cur_wave    = WAVE_SAW;
      cur_width   = PW_RESET;
      words_sent  = 0;
      samples_checked = 0;
      mismatches  = 0;
      csr_writes  = 0;
      quiet_cycles = 0;
      burst_left  = 0;
      gaps_on     = 1'b1;
      rx_mode     = 0;
      hold_req    = 1'b0;
      hold_left   = 0;
      rx_tick     = 0;
      foreach (wave_hits[i]) wave_hits[i] = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values first
      send_word(24'h200000, 24'h000400);
      send_word(24'h000010, 24'h000400);
      test_directed();
      test_backpressure();
      test_random(700);
      wait_drained();

      if (expected_samples.size() != 0) mismatches++;
      $display("%0d words sent, %0d samples checked, %0d register writes", words_sent,
               samples_checked, csr_writes);
      $display("per waveform: saw %0d square %0d triangle %0d sine %0d pulse %0d",
               wave_hits[0], wave_hits[1], wave_hits[2], wave_hits[3], wave_hits[4]);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> filelist.f
rtl/pbo_pkg.sv
rtl/pbo_if.sv
rtl/pbo_div_cell.sv
rtl/pbo_sine_cell.sv
rtl/pbo_out_buf.sv
rtl/polyblep_oscillator_sample_core.sv
bench/polyblep_oscillator_sample_core_tb.sv
